// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

    // Build defaults
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths
    localparam int VAL_W       = 32;
    localparam int OP_W        = 3;
    localparam int CAP_W       = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 104;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic                     REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0]         CAP_RESET    = 5'd16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

    // Result layout in the output tdata
    localparam int OUT_OK_LSB     = 0;
    localparam int OUT_POP_LSB    = 1;
    localparam int OUT_FRONT_LSB  = 33;
    localparam int OUT_REAR_LSB   = 65;
    localparam int OUT_EMPTY_LSB  = 97;
    localparam int OUT_FULL_LSB   = 98;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic exec;      // apply the accepted request
        logic fill;      // refresh an end cache from the slot memory
        logic load_out;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_read; // the request moves an end onto a stored slot
    } t_dp_sts;

endpackage

// ===== rtl/circular_deque_core.sv =====
// Double-ended queue held in a ring of DEPTH slots of DATA_WIDTH bits, of
// which the capacity register (byte address 0, reset 16, zero taken as one,
// values above DEPTH taken as DEPTH) puts a number in use. Each input request
// carries an opcode in s_axis_tuser (push front, push rear, pop front, pop
// rear, peek) and a push word in s_axis_tdata; each gives exactly one result
// with status, popped word, front and rear words after the operation (-1
// when empty) and the empty and full flags. A pop that leaves elements behind
// takes an extra fill step before the response, since the new end word comes
// through a registered read of the slot memory. The front and rear words are
// kept in registers beside the memory. A new request is taken while the
// previous result still waits in the output register. The slot memory needs
// no clearing after reset. Write capacity only while no request is in flight;
// contents and indices are kept across the write and the ends then wrap at
// the new capacity.
module circular_deque_core #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request: [31:0] push_value
    input  logic [cdq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // request: [2:0] opcode, rest zero
    input  logic [cdq_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // result: [0] ok, [32:1] popped_value, [64:33] front_value,
    // [96:65] rear_value, [97] is_empty, [98] is_full, [103:99] zero
    output logic [cdq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdq_pkg::APB_AW-1:0]        paddr,
    input  logic [cdq_pkg::APB_DW-1:0]        pwdata,
    output logic [cdq_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import cdq_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    logic             ok;
    logic [VAL_W-1:0] popped_value;
    logic [VAL_W-1:0] front_value;
    logic [VAL_W-1:0] rear_value;
    logic             is_empty;
    logic             is_full;

    // Capacity register, written in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_capacity) : '0;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_opcode       (s_axis_tuser[OP_W-1:0]),
        .i_push_value   (s_axis_tdata[VAL_W-1:0]),
        .i_capacity     (r_capacity),
        .o_ok           (ok),
        .o_popped_value (popped_value),
        .o_front_value  (front_value),
        .o_rear_value   (rear_value),
        .o_is_empty     (is_empty),
        .o_is_full      (is_full)
    );

    // Pack the result
    assign m_axis_tdata = {5'b0, is_full, is_empty, rear_value, front_value,
                           popped_value, ok};

endmodule

// ===== rtl/cdq_ctrl.sv =====
module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  cdq_pkg::t_dp_sts i_sts,
    output cdq_pkg::t_dp_cmd o_cmd
);
    import cdq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.need_read ? ST_FILL : ST_RESP;
                end
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/cdq_datapath.sv =====
module cdq_datapath #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdq_pkg::t_dp_cmd              i_cmd,
    output cdq_pkg::t_dp_sts              o_sts,
    input  logic [cdq_pkg::OP_W-1:0]      i_opcode,
    input  logic [cdq_pkg::VAL_W-1:0]     i_push_value,
    input  logic [cdq_pkg::CAP_W-1:0]     i_capacity,
    output logic                          o_ok,
    output logic [cdq_pkg::VAL_W-1:0]     o_popped_value,
    output logic [cdq_pkg::VAL_W-1:0]     o_front_value,
    output logic [cdq_pkg::VAL_W-1:0]     o_rear_value,
    output logic                          o_is_empty,
    output logic                          o_is_full
);
    import cdq_pkg::*;

    localparam int IW = $clog2(DEPTH);

    // Sign-extend or truncate a stored word to the result width
    function automatic logic [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
        return VAL_W'($signed(v));
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [IW-1:0]         r_front;
    logic [IW-1:0]         r_rear;
    logic                  r_empty;
    logic [DATA_WIDTH-1:0] r_front_val;
    logic [DATA_WIDTH-1:0] r_rear_val;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_fill_front;
    logic                  r_ok;
    logic [VAL_W-1:0]      r_popped;

    logic                  r_o_ok;
    logic [VAL_W-1:0]      r_o_popped;
    logic [VAL_W-1:0]      r_o_front;
    logic [VAL_W-1:0]      r_o_rear;
    logic                  r_o_empty;
    logic                  r_o_full;

    logic [IW-1:0]         last_idx;
    logic [IW-1:0]         front_next;
    logic [IW-1:0]         front_prev;
    logic [IW-1:0]         rear_next;
    logic [IW-1:0]         rear_prev;
    logic                  full;
    logic                  is_push;
    logic                  is_pop;
    logic                  push_ok;
    logic                  pop_ok;
    logic                  one_left;
    logic [IW-1:0]         wr_idx;
    logic [IW-1:0]         rd_idx;
    logic [DATA_WIDTH-1:0] wr_data;

    // Last usable slot: capacity clamped to one .. DEPTH
    always_comb begin
        if (i_capacity == '0) begin
            last_idx = '0;
        end else if (32'(i_capacity) > DEPTH) begin
            last_idx = IW'(DEPTH - 1);
        end else begin
            last_idx = IW'(i_capacity - CAP_W'(1));
        end
    end

    // Ring steps with wrap at the configured capacity
    assign front_next = (r_front >= last_idx) ? '0 : r_front + IW'(1);
    assign rear_next  = (r_rear  >= last_idx) ? '0 : r_rear  + IW'(1);
    assign front_prev = (r_front == '0) ? last_idx : r_front - IW'(1);
    assign rear_prev  = (r_rear  == '0) ? last_idx : r_rear  - IW'(1);

    assign full     = !r_empty && (rear_next == r_front);
    assign is_push  = (i_opcode == OP_PUSH_FRONT) || (i_opcode == OP_PUSH_REAR);
    assign is_pop   = (i_opcode == OP_POP_FRONT)  || (i_opcode == OP_POP_REAR);
    assign push_ok  = is_push && !full;
    assign pop_ok   = is_pop && !r_empty;
    assign one_left = (r_front == r_rear);
    assign wr_data  = DATA_WIDTH'(i_push_value);

    always_comb begin
        if (r_empty) begin
            wr_idx = '0;
        end else if (i_opcode == OP_PUSH_FRONT) begin
            wr_idx = front_prev;
        end else begin
            wr_idx = rear_next;
        end
    end

    assign rd_idx          = (i_opcode == OP_POP_FRONT) ? front_next : rear_prev;
    assign o_sts.need_read = pop_ok && !one_left;

    // Move the indices and the empty flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            if (push_ok) begin
                r_empty <= 1'b0;
                if (r_empty) begin
                    r_front <= '0;
                    r_rear  <= '0;
                end else if (i_opcode == OP_PUSH_FRONT) begin
                    r_front <= wr_idx;
                end else begin
                    r_rear  <= wr_idx;
                end
            end else if (pop_ok) begin
                if (one_left) begin
                    r_empty <= 1'b1;
                    r_front <= '0;
                    r_rear  <= '0;
                end else if (i_opcode == OP_POP_FRONT) begin
                    r_front <= rd_idx;
                end else begin
                    r_rear  <= rd_idx;
                end
            end
        end
    end

    // Slot memory: a write on each accepted push, a registered read per request
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push_ok) begin
            mem[wr_idx] <= wr_data;
        end
        if (i_cmd.exec) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    // End caches, status and popped word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok         <= push_ok || pop_ok;
            r_fill_front <= (i_opcode == OP_POP_FRONT);
            if (pop_ok) begin
                r_popped <= to_out((i_opcode == OP_POP_FRONT) ? r_front_val : r_rear_val);
            end else begin
                r_popped <= '1;
            end
            if (push_ok) begin
                if (r_empty) begin
                    r_front_val <= wr_data;
                    r_rear_val  <= wr_data;
                end else if (i_opcode == OP_PUSH_FRONT) begin
                    r_front_val <= wr_data;
                    if (wr_idx == r_rear) begin
                        r_rear_val <= wr_data;
                    end
                end else begin
                    r_rear_val <= wr_data;
                    if (wr_idx == r_front) begin
                        r_front_val <= wr_data;
                    end
                end
            end
        end else if (i_cmd.fill) begin
            if (r_fill_front) begin
                r_front_val <= r_rd_data;
            end else begin
                r_rear_val  <= r_rd_data;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_ok     <= r_ok;
            r_o_popped <= r_popped;
            r_o_front  <= r_empty ? '1 : to_out(r_front_val);
            r_o_rear   <= r_empty ? '1 : to_out(r_rear_val);
            r_o_empty  <= r_empty;
            r_o_full   <= full;
        end
    end

    assign o_ok           = r_o_ok;
    assign o_popped_value = r_o_popped;
    assign o_front_value  = r_o_front;
    assign o_rear_value   = r_o_rear;
    assign o_is_empty     = r_o_empty;
    assign o_is_full      = r_o_full;

endmodule

// ===== rtl/cdq_checker.sv =====
module cdq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cdq_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Never empty and full at once
    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[OUT_EMPTY_LSB] && m_axis_tdata[OUT_FULL_LSB]))
        else $error("empty and full both set");

    // Empty deque shows no front or rear word
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_EMPTY_LSB] |->
            (m_axis_tdata[OUT_FRONT_LSB +: VAL_W] == '1) &&
            (m_axis_tdata[OUT_REAR_LSB +: VAL_W] == '1))
        else $error("empty result carries end words");

    // Failed request (ok clear) reports no popped word
    a_fail_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_OK_LSB] |->
            (m_axis_tdata[OUT_POP_LSB +: VAL_W] == '1))
        else $error("popped word without success");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_circular_deque_core.sv =====
module tb_circular_deque_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    // Opcodes the block must ignore
    localparam logic [OP_W-1:0]  OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0]  OP_RSVD_HI = 3'd7;
    // Word reported for an empty end or a pop that found nothing
    localparam logic [VAL_W-1:0] NO_VALUE   = '1;

    localparam int SLOTS          = DEPTH_DEF;
    localparam int IX_W           = $clog2(SLOTS);
    localparam int SETTLE_CYC     = 8;
    localparam int REQS_PER_PHASE = 80;
    localparam int N_PHASES       = 9;
    localparam int HOLD_CYC       = 80;

    // One result, laid out as in the output tdata (ok in bit 0)
    typedef struct packed {
        logic             full;
        logic             empty;
        logic [VAL_W-1:0] rear;
        logic [VAL_W-1:0] front;
        logic [VAL_W-1:0] popped;
        logic             ok;
    } deq_result_t;

    // Directed step: either a capacity write or a request, with an optional
    // hand-written result
    typedef struct packed {
        logic              cfg;
        logic [APB_DW-1:0] wdata;
        logic [OP_W-1:0]   op;
        logic [VAL_W-1:0]  val;
        logic              known;
        deq_result_t       res;
    } dir_row_t;

    localparam int DIR_N = 24;
    // columns: cfg, wdata, op, val, known, {full, empty, rear, front, popped, ok}
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // empty deque right after reset
        '{1'b0, 32'd0, OP_POP_FRONT, 32'd0, 1'b1,
          '{1'b0, 1'b1, NO_VALUE, NO_VALUE, NO_VALUE, 1'b0}},
        '{1'b0, 32'd0, OP_POP_REAR, NO_VALUE, 1'b1,
          '{1'b0, 1'b1, NO_VALUE, NO_VALUE, NO_VALUE, 1'b0}},
        '{1'b0, 32'd0, OP_PEEK, 32'h5A5A_5A5A, 1'b1,
          '{1'b0, 1'b1, NO_VALUE, NO_VALUE, NO_VALUE, 1'b0}},
        // extreme words at both ends
        '{1'b0, 32'd0, OP_PUSH_REAR, 32'h7FFF_FFFF, 1'b1,
          '{1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, NO_VALUE, 1'b1}},
        '{1'b0, 32'd0, OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
          '{1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, NO_VALUE, 1'b1}},
        // peek and unused opcodes leave everything alone
        '{1'b0, 32'd0, OP_RSVD_LO, 32'd0, 1'b1,
          '{1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, NO_VALUE, 1'b0}},
        '{1'b0, 32'd0, OP_RSVD_HI, NO_VALUE, 1'b1,
          '{1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, NO_VALUE, 1'b0}},
        '{1'b0, 32'd0, OP_PEEK, 32'd0, 1'b1,
          '{1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, NO_VALUE, 1'b0}},
        '{1'b0, 32'd0, OP_POP_REAR, 32'd0, 1'b1,
          '{1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1}},
        // pop of the last element empties the deque
        '{1'b0, 32'd0, OP_POP_FRONT, 32'd0, 1'b1,
          '{1'b0, 1'b1, NO_VALUE, NO_VALUE, 32'h8000_0000, 1'b1}},
        '{1'b0, 32'd0, OP_PUSH_FRONT, 32'd0, 1'b1,
          '{1'b0, 1'b0, 32'd0, 32'd0, NO_VALUE, 1'b1}},
        '{1'b0, 32'd0, OP_POP_REAR, 32'd0, 1'b1,
          '{1'b0, 1'b1, NO_VALUE, NO_VALUE, 32'd0, 1'b1}},
        // two slots: fill, refuse, drain
        '{1'b1, 32'd2, OP_PEEK, 32'd0, 1'b0, '0},
        '{1'b0, 32'd0, OP_PUSH_REAR, 32'd1, 1'b0, '0},
        '{1'b0, 32'd0, OP_PUSH_FRONT, 32'd2, 1'b0, '0},
        '{1'b0, 32'd0, OP_PUSH_REAR, 32'd3, 1'b1,
          '{1'b1, 1'b0, 32'd1, 32'd2, NO_VALUE, 1'b0}},
        '{1'b0, 32'd0, OP_POP_FRONT, 32'd0, 1'b0, '0},
        '{1'b0, 32'd0, OP_POP_REAR, 32'd0, 1'b0, '0},
        // capacity zero behaves as one slot
        '{1'b1, 32'd0, OP_PEEK, 32'd0, 1'b0, '0},
        '{1'b0, 32'd0, OP_PUSH_REAR, NO_VALUE, 1'b1,
          '{1'b1, 1'b0, NO_VALUE, NO_VALUE, NO_VALUE, 1'b1}},
        '{1'b0, 32'd0, OP_PUSH_FRONT, 32'd5, 1'b1,
          '{1'b1, 1'b0, NO_VALUE, NO_VALUE, NO_VALUE, 1'b0}},
        '{1'b0, 32'd0, OP_POP_FRONT, 32'd0, 1'b0, '0},
        // all ones saturates to the built depth
        '{1'b1, 32'hFFFF_FFFF, OP_PEEK, 32'd0, 1'b0, '0},
        '{1'b0, 32'd0, OP_PUSH_REAR, 32'h1234_5678, 1'b0, '0}
    };

    // Capacity per random phase, and whether elements may stay across the write
    localparam logic [APB_DW-1:0] PHASE_CAP [N_PHASES] = '{
        32'd16, 32'd1, 32'd2, 32'hFFFF_FFE5, 32'd0, 32'd12, 32'd31, 32'd9, 32'd16
    };
    localparam bit PHASE_KEEP [N_PHASES] = '{0, 0, 0, 0, 0, 1, 0, 1, 1};

    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    circular_deque_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow deque
    logic [VAL_W-1:0] slot_mem  [SLOTS];
    bit               slot_seen [SLOTS];
    logic [IX_W-1:0]  fr_ix    = '0;
    logic [IX_W-1:0]  rr_ix    = '0;
    bit               dq_empty = 1'b1;
    logic [CAP_W-1:0] cap_reg  = CAP_RESET;

    deq_result_t pending_results [$];
    int          mismatch_cnt = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          rcv_hold_len = 0;

    function automatic int cap_eff(logic [CAP_W-1:0] c);
        if (c == 0) return 1;
        if (c > SLOTS) return SLOTS;
        return int'(c);
    endfunction

    function automatic logic [IX_W-1:0] ring_next(logic [IX_W-1:0] i, int nc);
        return (int'(i) + 1 >= nc) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IX_W-1:0] ring_prev(logic [IX_W-1:0] i, int nc);
        return (i == 0) ? IX_W'(nc - 1) : i - 1'b1;
    endfunction

    function automatic bit ring_full();
        return !dq_empty && ring_next(rr_ix, cap_eff(cap_reg)) == fr_ix;
    endfunction

    // Contents survive a capacity change only if both ends stay in range and
    // every slot between them has been written
    function automatic bit ring_keeps(int nc);
        logic [IX_W-1:0] i;
        if (dq_empty) return 1'b1;
        if (int'(fr_ix) >= nc || int'(rr_ix) >= nc) return 1'b0;
        i = fr_ix;
        while (i != rr_ix) begin
            i = ring_next(i, nc);
            if (!slot_seen[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one request to the shadow deque and return its result
    function automatic deq_result_t deque_step(logic [OP_W-1:0] op, logic [VAL_W-1:0] val);
        deq_result_t r;
        int          nc;
        nc       = cap_eff(cap_reg);
        r.ok     = 1'b0;
        r.popped = NO_VALUE;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (!ring_full()) begin
                    if (dq_empty) begin
                        fr_ix    = '0;
                        rr_ix    = '0;
                        dq_empty = 1'b0;
                    end else if (op == OP_PUSH_FRONT) begin
                        fr_ix = ring_prev(fr_ix, nc);
                    end else begin
                        rr_ix = ring_next(rr_ix, nc);
                    end
                    // the new end is the slot just written
                    slot_mem[(op == OP_PUSH_FRONT) ? fr_ix : rr_ix]  = val;
                    slot_seen[(op == OP_PUSH_FRONT) ? fr_ix : rr_ix] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (!dq_empty) begin
                    r.popped = slot_mem[(op == OP_POP_FRONT) ? fr_ix : rr_ix];
                    if (fr_ix == rr_ix) begin
                        dq_empty = 1'b1;
                        fr_ix    = '0;
                        rr_ix    = '0;
                    end else if (op == OP_POP_FRONT) begin
                        fr_ix = ring_next(fr_ix, nc);
                    end else begin
                        rr_ix = ring_prev(rr_ix, nc);
                    end
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.front = dq_empty ? NO_VALUE : slot_mem[fr_ix];
        r.rear  = dq_empty ? NO_VALUE : slot_mem[rr_ix];
        r.empty = dq_empty;
        r.full  = ring_full();
        return r;
    endfunction

    // Offer one request, idling first at random; predict once it is taken
    task automatic send_req(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                            input bit known, input deq_result_t known_res);
        deq_result_t guess;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= IN_TUSER_W'(op);
        do @(posedge i_clk); while (!s_axis_tready);
        guess = deque_step(op, val);
        pending_results.push_back(known ? known_res : guess);
    endtask

    // Stop offering, wait for every outstanding result, then let the block go quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [APB_DW-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = wdata[CAP_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[circular_deque_core] ERROR");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when asked
    initial begin : rcv_side
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rcv_hold_len != 0) begin
                hold_left    = rcv_hold_len;
                rcv_hold_len = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    deq_result_t got_res;
    deq_result_t want_res;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = deq_result_t'(m_axis_tdata[OUT_FULL_LSB:0]);
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("ok", VAL_W'(want_res.ok), VAL_W'(got_res.ok));
                check_field("popped_value", want_res.popped, got_res.popped);
                check_field("front_value", want_res.front, got_res.front);
                check_field("rear_value", want_res.rear, got_res.rear);
                check_field("is_empty", VAL_W'(want_res.empty), VAL_W'(got_res.empty));
                check_field("is_full", VAL_W'(want_res.full), VAL_W'(got_res.full));
            end
        end
    end

    initial begin : stim
        int               burst_left;
        int               push_bias;
        int               pick;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        snd_idle_pct  = 21;
        rcv_idle_pct  = 65;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int k = 0; k < DIR_N; k++) begin
            if (DIR_ROWS[k].cfg) begin
                settle_block();
                write_capacity(DIR_ROWS[k].wdata);
            end else begin
                send_req(DIR_ROWS[k].op, DIR_ROWS[k].val, DIR_ROWS[k].known, DIR_ROWS[k].res);
            end
        end

        // Random phases, one capacity each
        for (int ph = 0; ph < N_PHASES; ph++) begin
            snd_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 65 : 0;
            rcv_idle_pct = (ph < 3) ? 65 : (ph < 6) ? 21 : 0;

            // drain unless the contents stay meaningful under the new capacity
            if (!(PHASE_KEEP[ph] && ring_keeps(cap_eff(PHASE_CAP[ph][CAP_W-1:0])))) begin
                while (!dq_empty)
                    send_req($urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR,
                             $urandom(), 1'b0, '0);
            end
            settle_block();
            write_capacity(PHASE_CAP[ph]);

            // back up the result side so the input stalls
            if (ph == 1 || ph == 7) rcv_hold_len = HOLD_CYC;

            burst_left = 0;
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                // bursts lean toward pushes or pops to reach full and empty
                if (burst_left == 0) begin
                    burst_left = $urandom_range(20, 4);
                    case ($urandom_range(2))
                        0:       push_bias = 75;
                        1:       push_bias = 20;
                        default: push_bias = 47;
                    endcase
                end
                burst_left--;

                pick = $urandom_range(99);
                if (pick < 6)
                    op = (pick < 2) ? OP_PEEK : OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
                else if (pick < 6 + push_bias)
                    op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                else
                    op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;

                case ($urandom_range(7))
                    0:       val = '0;
                    1:       val = NO_VALUE;
                    2:       val = 32'h8000_0000;
                    3:       val = 32'h7FFF_FFFF;
                    default: val = $urandom();
                endcase
                send_req(op, val, 1'b0, '0);
            end
        end

        settle_block();
        if (mismatch_cnt == 0) begin
            $display("[circular_deque_core] OK");
        end else begin
            $display("[circular_deque_core] ERROR");
        end
        $finish;
    end

endmodule
